FILE: rtl/core/acm_pkg.sv
`default_nettype none
package acm_pkg;

	localparam int unsigned HOURS_PER_DAY    = 24;
	localparam int unsigned MINUTES_PER_HOUR = 60;
	localparam int unsigned ALARM_HOUR_RESET = 7;

	// event kinds
	localparam logic [2:0] EV_TICK  = 3'd0;
	localparam logic [2:0] EV_UP    = 3'd1;
	localparam logic [2:0] EV_DOWN  = 3'd2;
	localparam logic [2:0] EV_PRESS = 3'd3;
	localparam logic [2:0] EV_LONG  = 3'd4;

	// commands to the clock chip
	localparam logic [1:0] CMD_NONE          = 2'd0;
	localparam logic [1:0] CMD_WRITE_TIME    = 2'd1;
	localparam logic [1:0] CMD_PROGRAM_ALARM = 2'd2;
	localparam logic [1:0] CMD_CLEAR_FLAGS   = 2'd3;

	// mode codes as seen on the result
	localparam logic [2:0] MODE_CODE_CLOCK   = 3'd0;
	localparam logic [2:0] MODE_CODE_SET_H   = 3'd1;
	localparam logic [2:0] MODE_CODE_SET_M   = 3'd2;
	localparam logic [2:0] MODE_CODE_ALARM_H = 3'd3;
	localparam logic [2:0] MODE_CODE_ALARM_M = 3'd4;

	typedef enum logic [4:0] {
		MODE_CLOCK   = 5'b00001,
		MODE_SET_H   = 5'b00010,
		MODE_SET_M   = 5'b00100,
		MODE_ALARM_H = 5'b01000,
		MODE_ALARM_M = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [2:0] func;
		logic [4:0] rtc_hour;
		logic [5:0] rtc_minute;
		logic [5:0] rtc_second;
		logic       rtc_read_ok;
		logic       alarm_matched;
	} ev_t;

	typedef struct packed {
		logic [4:0] shown_hour;
		logic [5:0] shown_minute;
		logic [5:0] shown_second;
		logic [4:0] wake_hour;
		logic [5:0] wake_minute;
		logic [2:0] edit_mode;
		logic       alarm_armed;
		logic       alarm_ringing;
		logic [1:0] clock_command;
		logic       repaint;
	} res_t;

	typedef struct packed {
		mode_t      mode;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [4:0] wake_hour;
		logic [5:0] wake_minute;
		logic       armed;
		logic       ringing;
	} state_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       paint;
	} ctl_t;

	// +/-1 mod 24 for any 5-bit held value; sum stays below 3*24
	function automatic logic [4:0] wrap_hour(input logic [4:0] v, input logic up);
		logic [6:0] s;
		s = {2'b00, v} + (up ? 7'(HOURS_PER_DAY + 1) : 7'(HOURS_PER_DAY - 1));
		if (s >= 7'(2 * HOURS_PER_DAY))
			s = s - 7'(2 * HOURS_PER_DAY);
		else if (s >= 7'(HOURS_PER_DAY))
			s = s - 7'(HOURS_PER_DAY);
		return s[4:0];
	endfunction

	// +/-1 mod 60 for any 6-bit held value; sum stays below 3*60
	function automatic logic [5:0] wrap_minute(input logic [5:0] v, input logic up);
		logic [7:0] s;
		s = {2'b00, v} + (up ? 8'(MINUTES_PER_HOUR + 1) : 8'(MINUTES_PER_HOUR - 1));
		if (s >= 8'(2 * MINUTES_PER_HOUR))
			s = s - 8'(2 * MINUTES_PER_HOUR);
		else if (s >= 8'(MINUTES_PER_HOUR))
			s = s - 8'(MINUTES_PER_HOUR);
		return s[5:0];
	endfunction

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		case (m)
			MODE_CLOCK:   c = MODE_CODE_CLOCK;
			MODE_SET_H:   c = MODE_CODE_SET_H;
			MODE_SET_M:   c = MODE_CODE_SET_M;
			MODE_ALARM_H: c = MODE_CODE_ALARM_H;
			MODE_ALARM_M: c = MODE_CODE_ALARM_M;
			default:      c = MODE_CODE_CLOCK;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/acm_ev_if.sv
`default_nettype none
interface acm_ev_if;
	import acm_pkg::*;
	logic valid;
	logic ready;
	ev_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/acm_res_if.sv
`default_nettype none
interface acm_res_if;
	import acm_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/acm_next.sv
`default_nettype none
module acm_next (
	input  acm_pkg::state_t cur,
	input  acm_pkg::ev_t    ev,
	output acm_pkg::state_t nxt,
	output acm_pkg::ctl_t   ctl
);
	import acm_pkg::*;

	logic up;
	assign up = (ev.func == EV_UP);

	always_comb begin
		nxt       = cur;
		ctl.cmd   = CMD_NONE;
		ctl.paint = 1'b0;
		case (ev.func)
			EV_TICK: begin
				if (cur.mode == MODE_CLOCK && ev.rtc_read_ok) begin
					nxt.hour   = ev.rtc_hour;
					nxt.minute = ev.rtc_minute;
					nxt.second = ev.rtc_second;
					ctl.paint  = 1'b1;
					if (cur.armed && !cur.ringing && ev.alarm_matched)
						nxt.ringing = 1'b1;
				end
			end
			EV_UP, EV_DOWN: begin
				ctl.paint = 1'b1;
				case (cur.mode)
					MODE_SET_H:   nxt.hour        = wrap_hour(cur.hour, up);
					MODE_SET_M:   nxt.minute      = wrap_minute(cur.minute, up);
					MODE_ALARM_H: nxt.wake_hour   = wrap_hour(cur.wake_hour, up);
					MODE_ALARM_M: nxt.wake_minute = wrap_minute(cur.wake_minute, up);
					default:      ctl.paint       = 1'b0;
				endcase
			end
			EV_PRESS: begin
				ctl.paint = 1'b1;
				if (cur.ringing) begin
					nxt.ringing = 1'b0;
					ctl.cmd     = CMD_CLEAR_FLAGS;
				end else begin
					case (cur.mode)
						MODE_CLOCK:   nxt.mode = MODE_SET_H;
						MODE_SET_H:   nxt.mode = MODE_SET_M;
						MODE_SET_M: begin
							nxt.second = '0;
							nxt.mode   = MODE_ALARM_H;
							ctl.cmd    = CMD_WRITE_TIME;
						end
						MODE_ALARM_H: nxt.mode = MODE_ALARM_M;
						default: begin
							nxt.mode = MODE_CLOCK;
							ctl.cmd  = CMD_PROGRAM_ALARM;
						end
					endcase
				end
			end
			EV_LONG: begin
				ctl.paint = 1'b1;
				nxt.armed = !cur.armed;
				if (cur.armed && cur.ringing) begin
					nxt.ringing = 1'b0;
					ctl.cmd     = CMD_CLEAR_FLAGS;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/core/alarm_clock_mode_controller.sv
// Path: an accepted event is held in the input stage, then moves to the result stage
// (two-stage path). Throughput: one event per cycle unless res stalls; both stages
// hold an item, and the state registers update as an event moves into the result stage.
// Reset: arst_n low clears both stages, mode to clock face, time 00:00:00,
// alarm 07:00, armed set, ringing clear.
`default_nettype none
module alarm_clock_mode_controller (
	input  wire logic clk,
	input  wire logic arst_n,
	acm_ev_if.sink    ev,
	acm_res_if.source res
);
	import acm_pkg::*;

	// input stage
	logic   valid_s1;
	ev_t    item_s1;
	// result stage
	logic   valid_s2;
	res_t   item_s2;

	// architectural state
	state_t st_q;
	state_t st_nxt;
	ctl_t   ctl;

	logic adv;   // input stage moves into result stage
	assign adv      = valid_s1 && (!valid_s2 || res.ready);
	assign ev.ready = !valid_s1 || adv;

	acm_next u_next (
		.cur(st_q),
		.ev (item_s1),
		.nxt(st_nxt),
		.ctl(ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ev.ready) begin
			valid_s1 <= ev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ev.valid && ev.ready)
			item_s1 <= ev.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// state follows each event in order; the next event sees the updated state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode        <= MODE_CLOCK;
			st_q.hour        <= '0;
			st_q.minute      <= '0;
			st_q.second      <= '0;
			st_q.wake_hour   <= 5'(ALARM_HOUR_RESET);
			st_q.wake_minute <= '0;
			st_q.armed       <= 1'b1;
			st_q.ringing     <= 1'b0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2.shown_hour    <= st_nxt.hour;
			item_s2.shown_minute  <= st_nxt.minute;
			item_s2.shown_second  <= st_nxt.second;
			item_s2.wake_hour     <= st_nxt.wake_hour;
			item_s2.wake_minute   <= st_nxt.wake_minute;
			item_s2.edit_mode     <= mode_code(st_nxt.mode);
			item_s2.alarm_armed   <= st_nxt.armed;
			item_s2.alarm_ringing <= st_nxt.ringing;
			item_s2.clock_command <= ctl.cmd;
			item_s2.repaint       <= ctl.paint;
		end
	end

	assign res.valid = valid_s2;
	assign res.data  = item_s2;

	// write-time command only when leaving set minute: seconds zeroed, alarm hour next
	a_write_time: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.clock_command == CMD_WRITE_TIME
		|-> res.data.shown_second == '0 && res.data.edit_mode == MODE_CODE_ALARM_H)
		else $error("write-time command with wrong mode or seconds");

	// clearing the alarm flags always leaves the alarm silent
	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.clock_command == CMD_CLEAR_FLAGS |-> !res.data.alarm_ringing)
		else $error("clear-flags command while still ringing");

	// every command comes from a press or a long press, both of which always repaint
	a_cmd_paint: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.clock_command != CMD_NONE |-> res.data.repaint)
		else $error("command issued without repaint");

	// a full input stage that cannot advance must back-pressure the source
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !res.ready |-> !ev.ready)
		else $error("input accepted while both stages are blocked");

endmodule
`default_nettype wire
